[rtl/core/cgcp_pkg.sv]
// shared types, codes and constants of the container parser
package cgcp_pkg;

  localparam int HDR_BYTES = 14;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  localparam logic [31:0] TAG_ADMIN = 32'h4E4D_4441;
  localparam logic [31:0] TAG_USER  = 32'h5245_5355;
  localparam logic [31:0] TAG_NOTE  = 32'h4554_4F4E;

  localparam logic [7:0] MAGIC_BYTES [4] = '{8'h46, 8'h5A, 8'h30, 8'h31};

  localparam logic [20:0] PAYLOAD_LIMIT_RESET    = 21'h10_0000;
  localparam logic        CRC_CHECK_RESET        = 1'b1;
  localparam logic [15:0] EXPECTED_VERSION_RESET = 16'h0001;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 21;

  localparam logic [CFG_INDEX_W-1:0] REG_PAYLOAD_LIMIT    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CRC_CHECK_ENABLE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_VERSION = 2'd2;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_TOO_SMALL   = 3'd1;
  localparam logic [2:0] ST_BAD_MAGIC   = 3'd2;
  localparam logic [2:0] ST_BAD_VERSION = 3'd3;
  localparam logic [2:0] ST_TOO_LARGE   = 3'd4;
  localparam logic [2:0] ST_TRUNCATED   = 3'd5;
  localparam logic [2:0] ST_BAD_CRC     = 3'd6;
  localparam logic [2:0] ST_UNKNOWN_REC = 3'd7;

  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_ADMIN = 2'd1;
  localparam logic [1:0] KIND_USER  = 2'd2;
  localparam logic [1:0] KIND_NOTE  = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_word_t;

  typedef struct packed {
    logic [20:0] payload_limit;
    logic        crc_check_enable;
    logic [15:0] expected_version;
  } cfg_t;

endpackage

[rtl/core/cgcp_if.sv]
// channel interfaces: byte input, status output, configuration write
interface cgcp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;
  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

interface cgcp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [1:0]  record_kind;
  logic [31:0] user_id;
  logic [7:0]  name_length;
  logic        name_fits;
  logic [31:0] payload_length;
  logic [31:0] computed_crc;
  modport source (output valid, output status, output record_kind, output user_id,
                  output name_length, output name_fits, output payload_length,
                  output computed_crc, input ready);
  modport sink (input valid, input status, input record_kind, input user_id,
                input name_length, input name_fits, input payload_length,
                input computed_crc, output ready);
endinterface

interface cgcp_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [20:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/core/crc_guarded_container_parser.sv]
// top level of the crc guarded container parser
//
// data_ch takes the file one word (byte) per cycle, final_byte set on the last
// word. The first 14 words form the header (magic, version, length, crc); the
// payload that follows runs through a reflected crc-32, one byte per cycle.
// result_ch carries one status word per file, registered once the final
// word has passed the input register and then the result
// register. Throughput is one word per cycle, set by the one-byte crc step
// and the status compare chain between the two registers.
// When result_ch stalls, ordinary words keep flowing; a final word of the next
// file waits in the input register until the held result is taken.
// cfg_ch writes the payload limit, crc_check_enable and expected_version by
// index, always ready; write only while no file is in flight. Other indexes
// are ignored.
// Reset (rst, synchronous) clears the file state and the channels and loads
// the register defaults; the block is ready in the next cycle.
module crc_guarded_container_parser
  import cgcp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  cgcp_in_if.sink     data_ch,
  cgcp_out_if.source  result_ch,
  cgcp_cfg_if.sink    cfg_ch
);

  cfg_t     cfg;
  in_word_t word;
  logic     word_valid;
  logic     advance;

  cgcp_cfg u_cfg (
    .clk    (clk),
    .rst    (rst),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  cgcp_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .data_ch    (data_ch),
    .advance    (advance),
    .word_valid (word_valid),
    .word       (word)
  );

  cgcp_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .word_valid (word_valid),
    .word       (word),
    .cfg        (cfg),
    .advance    (advance),
    .result_ch  (result_ch)
  );

  a_kind_only_ok: assert property (@(posedge clk) disable iff (rst)
    result_ch.valid && (result_ch.status != ST_OK) |->
      (result_ch.record_kind == KIND_NONE) && !result_ch.name_fits &&
      (result_ch.user_id == 32'd0) && (result_ch.name_length == 8'd0))
    else $error("record fields set on a failed status");

  a_small_clears: assert property (@(posedge clk) disable iff (rst)
    result_ch.valid && (result_ch.status == ST_TOO_SMALL) |->
      (result_ch.payload_length == 32'd0) && (result_ch.computed_crc == 32'd0))
    else $error("short file reports length or crc");

  a_fits_admin: assert property (@(posedge clk) disable iff (rst)
    result_ch.valid && result_ch.name_fits |-> (result_ch.record_kind == KIND_ADMIN))
    else $error("name_fits set outside an admin record");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !result_ch.valid && !word_valid)
    else $error("result or input register valid after reset");

endmodule

[rtl/core/cgcp_cfg.sv]
// configuration registers
module cgcp_cfg
  import cgcp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  cgcp_cfg_if.sink   cfg_ch,
  output cfg_t       cfg
);

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.payload_limit    <= PAYLOAD_LIMIT_RESET;
      cfg.crc_check_enable <= CRC_CHECK_RESET;
      cfg.expected_version <= EXPECTED_VERSION_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_PAYLOAD_LIMIT:    cfg.payload_limit    <= cfg_ch.data;
        REG_CRC_CHECK_ENABLE: cfg.crc_check_enable <= cfg_ch.data[0];
        REG_EXPECTED_VERSION: cfg.expected_version <= cfg_ch.data[15:0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/core/cgcp_in_stage.sv]
// input register for one word of the file
module cgcp_in_stage
  import cgcp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  cgcp_in_if.sink  data_ch,
  input  logic     advance,
  output logic     word_valid,
  output in_word_t word
);

  assign data_ch.ready = !word_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (data_ch.valid && data_ch.ready) begin
      word_valid <= 1'b1;
    end else if (advance) begin
      word_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (data_ch.valid && data_ch.ready) begin
      word.data_byte  <= data_ch.data_byte;
      word.final_byte <= data_ch.final_byte;
    end
  end

endmodule

[rtl/core/cgcp_parse.sv]
// header capture, payload crc, record classification and result register
module cgcp_parse
  import cgcp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         word_valid,
  input  in_word_t     word,
  input  cfg_t         cfg,
  output logic         advance,
  cgcp_out_if.source   result_ch
);

  logic [31:0] bytes_seen, bytes_seen_next;
  logic        magic_matches, magic_matches_next;
  logic [15:0] header_version, header_version_next;
  logic [31:0] header_length, header_length_next;
  logic [31:0] header_crc, header_crc_next;
  logic [31:0] running_crc, running_crc_next;
  logic [31:0] record_tag, record_tag_next;
  logic [31:0] record_detail, record_detail_next;

  logic [31:0] off;
  logic [7:0]  b;
  logic [2:0]  status_c;
  logic [1:0]  kind_c;
  logic [31:0] uid_c;
  logic [7:0]  nlen_c;
  logic        fits_c;
  logic [31:0] len_c;
  logic [31:0] crc_c;
  logic        finish;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] d);
    logic [31:0] c;
    c = crc_in ^ {24'd0, d};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

  assign advance = word_valid && (!word.final_byte || !result_ch.valid || result_ch.ready);
  assign finish  = advance && word.final_byte;
  assign b       = word.data_byte;
  assign off     = bytes_seen - 32'(HDR_BYTES);

  always_comb begin
    magic_matches_next  = magic_matches;
    header_version_next = header_version;
    header_length_next  = header_length;
    header_crc_next     = header_crc;
    running_crc_next    = running_crc;
    record_tag_next     = record_tag;
    record_detail_next  = record_detail;
    if (bytes_seen < 32'd4) begin
      if (b != MAGIC_BYTES[bytes_seen[1:0]]) begin
        magic_matches_next = 1'b0;
      end
    end else if (bytes_seen < 32'd6) begin
      header_version_next[{bytes_seen[0], 3'b000} +: 8] = b;
    end else if (bytes_seen < 32'd10) begin
      header_length_next[{bytes_seen[1:0] - 2'd2, 3'b000} +: 8] = b;
    end else if (bytes_seen < 32'(HDR_BYTES)) begin
      header_crc_next[{bytes_seen[1:0] - 2'd2, 3'b000} +: 8] = b;
    end else if (off < header_length) begin
      running_crc_next = crc_byte(running_crc, b);
      if (off < 32'd4) begin
        record_tag_next[{off[1:0], 3'b000} +: 8] = b;
      end else if (off < 32'd8) begin
        record_detail_next[{off[1:0], 3'b000} +: 8] = b;
      end
    end
    bytes_seen_next = (bytes_seen == ALL_ONES) ? bytes_seen : bytes_seen + 32'd1;
  end

  // status in check order, taken from the state after this word
  always_comb begin
    len_c    = header_length_next;
    crc_c    = ~running_crc_next;
    kind_c   = KIND_NONE;
    uid_c    = 32'd0;
    nlen_c   = 8'd0;
    fits_c   = 1'b0;
    if (bytes_seen_next < 32'(HDR_BYTES)) begin
      status_c = ST_TOO_SMALL;
      len_c    = 32'd0;
      crc_c    = 32'd0;
    end else if (!magic_matches_next) begin
      status_c = ST_BAD_MAGIC;
    end else if (header_version_next != cfg.expected_version) begin
      status_c = ST_BAD_VERSION;
    end else if (len_c > {11'd0, cfg.payload_limit}) begin
      status_c = ST_TOO_LARGE;
    end else if (({1'b0, len_c} + 33'(HDR_BYTES)) > {1'b0, bytes_seen_next}) begin
      status_c = ST_TRUNCATED;
    end else if (cfg.crc_check_enable && (crc_c != header_crc_next)) begin
      status_c = ST_BAD_CRC;
    end else if (len_c < 32'd4) begin
      status_c = ST_UNKNOWN_REC;
    end else if (record_tag_next == TAG_ADMIN) begin
      status_c = ST_OK;
      kind_c   = KIND_ADMIN;
      if (len_c >= 32'd5) begin
        nlen_c = record_detail_next[7:0];
        fits_c = ({24'd0, record_detail_next[7:0]} + 32'd5) <= len_c;
      end
    end else if (record_tag_next == TAG_USER) begin
      status_c = ST_OK;
      kind_c   = KIND_USER;
      if (len_c >= 32'd8) begin
        uid_c = record_detail_next;
      end
    end else if (record_tag_next == TAG_NOTE) begin
      status_c = ST_OK;
      kind_c   = KIND_NOTE;
    end else begin
      status_c = ST_UNKNOWN_REC;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || finish) begin
      bytes_seen     <= 32'd0;
      magic_matches  <= 1'b1;
      header_version <= 16'd0;
      header_length  <= 32'd0;
      header_crc     <= 32'd0;
      running_crc    <= ALL_ONES;
      record_tag     <= 32'd0;
      record_detail  <= 32'd0;
    end else if (advance) begin
      bytes_seen     <= bytes_seen_next;
      magic_matches  <= magic_matches_next;
      header_version <= header_version_next;
      header_length  <= header_length_next;
      header_crc     <= header_crc_next;
      running_crc    <= running_crc_next;
      record_tag     <= record_tag_next;
      record_detail  <= record_detail_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_ch.valid <= 1'b0;
    end else if (finish) begin
      result_ch.valid <= 1'b1;
    end else if (result_ch.ready) begin
      result_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      result_ch.status         <= status_c;
      result_ch.record_kind    <= kind_c;
      result_ch.user_id        <= uid_c;
      result_ch.name_length    <= nlen_c;
      result_ch.name_fits      <= fits_c;
      result_ch.payload_length <= len_c;
      result_ch.computed_crc   <= crc_c;
    end
  end

endmodule
